// ----- rtl/segment_segment_intersection_macros.svh -----
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Immediate-to-next and same-cycle implication checks for the RTL files.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define SSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment intersection check failed");
`define SSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment intersection check failed");
`else
`define SSI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ssi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, word types and pipeline records shared by the intersection block.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int LO_W       = COORD_BITS;
    localparam int HI_W       = WIDE_W - LO_W;
    localparam int MUL_W      = WIDE_W + DIFF_W;
    localparam int QUO_BITS   = DIFF_W + 1;
    localparam int NPTS       = 4;

    localparam logic [1:0] K_NONE    = 2'd0;
    localparam logic [1:0] K_CROSS   = 2'd1;
    localparam logic [1:0] K_OVERLAP = 2'd2;
    localparam logic [1:0] K_DEGEN   = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [1:0]                   kind;
        logic                         last;
    } t_out_word;

    typedef struct packed {
        t_in_word        pts;
        logic [1:0]      kind;
        logic [NPTS-1:0] mask;
    } t_tag;

    typedef struct packed {
        logic [MUL_W-1:0]    rem_x;
        logic [MUL_W-1:0]    rem_y;
        logic [QUO_BITS-1:0] quo_x;
        logic [QUO_BITS-1:0] quo_y;
        logic [WIDE_W-1:0]   dvs;
        logic                neg_x;
        logic                neg_y;
        t_tag                tag;
    } t_div;

endpackage

// ----- rtl/ssi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection front end
// Six stages: differences, products, determinants, classification with split
// products, product assembly, and magnitudes for the divider.
// ----------------------------------------------------------------------------
module ssi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  ssi_pkg::t_in_word i_word,
    output logic            o_valid,
    output ssi_pkg::t_div   o_div
);

    function automatic logic in_span(
        input logic signed [ssi_pkg::COORD_BITS-1:0] v,
        input logic signed [ssi_pkg::COORD_BITS-1:0] e0,
        input logic signed [ssi_pkg::COORD_BITS-1:0] e1
    );
        logic r;
        if (e0 <= e1) begin
            r = (e0 <= v) && (v <= e1);
        end else begin
            r = (e1 <= v) && (v <= e0);
        end
        return r;
    endfunction

    function automatic logic unit_range(
        input logic signed [ssi_pkg::WIDE_W-1:0] n,
        input logic signed [ssi_pkg::WIDE_W-1:0] d
    );
        logic r;
        if (d[ssi_pkg::WIDE_W-1]) begin
            r = (n <= 0) && (n >= d);
        end else begin
            r = (n >= 0) && (n <= d);
        end
        return r;
    endfunction

    logic [5:0] r_v;

    ssi_pkg::t_in_word r1_pts, r2_pts, r3_pts;
    logic r1_degen, r2_degen, r3_degen;
    logic signed [ssi_pkg::DIFF_W-1:0] r1_dax, r1_day, r1_dbx, r1_dby, r1_dsx, r1_dsy;
    logic signed [ssi_pkg::DIFF_W-1:0] r2_dax, r2_day, r3_dax, r3_day;
    logic signed [ssi_pkg::PROD_W-1:0] r2_pbyax, r2_pbxay, r2_pbxsy, r2_pbysx;
    logic signed [ssi_pkg::PROD_W-1:0] r2_paxsy, r2_paysx;
    logic [ssi_pkg::NPTS-1:0] r2_mask, r3_mask;
    logic signed [ssi_pkg::WIDE_W-1:0] r3_den, r3_num1, r3_num2;
    ssi_pkg::t_tag r4_tag, r5_tag;
    logic signed [ssi_pkg::WIDE_W-1:0] r4_den, r5_den;
    logic signed [ssi_pkg::LO_W+ssi_pkg::DIFF_W:0] r4_plx, r4_ply;
    logic signed [ssi_pkg::HI_W+ssi_pkg::DIFF_W-1:0] r4_phx, r4_phy;
    logic signed [ssi_pkg::MUL_W-1:0] r5_px, r5_py;
    ssi_pkg::t_div r6_div;

    ssi_pkg::t_tag n4_tag;
    logic n4_cross;
    logic signed [ssi_pkg::LO_W:0] n4_lo;
    logic signed [ssi_pkg::HI_W-1:0] n4_hi;
    ssi_pkg::t_div n6_div;

    always_comb begin
        n4_cross = unit_range(r3_num1, r3_den) && unit_range(r3_num2, r3_den);
        n4_tag.pts = r3_pts;
        n4_tag.mask = r3_mask;
        if (r3_degen) begin
            n4_tag.kind = ssi_pkg::K_DEGEN;
        end else if (r3_den != 0) begin
            n4_tag.kind = n4_cross ? ssi_pkg::K_CROSS : ssi_pkg::K_NONE;
        end else if ((r3_num2 == 0) && (r3_mask != '0)) begin
            n4_tag.kind = ssi_pkg::K_OVERLAP;
        end else begin
            n4_tag.kind = ssi_pkg::K_NONE;
        end
        n4_lo = $signed({1'b0, r3_num1[ssi_pkg::LO_W-1:0]});
        n4_hi = r3_num1[ssi_pkg::WIDE_W-1:ssi_pkg::LO_W];
    end

    always_comb begin
        n6_div.tag = r5_tag;
        n6_div.quo_x = '0;
        n6_div.quo_y = '0;
        n6_div.neg_x = r5_px[ssi_pkg::MUL_W-1] ^ r5_den[ssi_pkg::WIDE_W-1];
        n6_div.neg_y = r5_py[ssi_pkg::MUL_W-1] ^ r5_den[ssi_pkg::WIDE_W-1];
        n6_div.rem_x = r5_px[ssi_pkg::MUL_W-1] ? -r5_px : r5_px;
        n6_div.rem_y = r5_py[ssi_pkg::MUL_W-1] ? -r5_py : r5_py;
        n6_div.dvs = r5_den[ssi_pkg::WIDE_W-1] ? -r5_den : r5_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pts <= i_word;
            r1_degen <= (i_word.a_start_x == i_word.a_end_x)
                     && (i_word.a_start_y == i_word.a_end_y);
            r1_dax <= ssi_pkg::DIFF_W'(i_word.a_end_x) - ssi_pkg::DIFF_W'(i_word.a_start_x);
            r1_day <= ssi_pkg::DIFF_W'(i_word.a_end_y) - ssi_pkg::DIFF_W'(i_word.a_start_y);
            r1_dbx <= ssi_pkg::DIFF_W'(i_word.b_end_x) - ssi_pkg::DIFF_W'(i_word.b_start_x);
            r1_dby <= ssi_pkg::DIFF_W'(i_word.b_end_y) - ssi_pkg::DIFF_W'(i_word.b_start_y);
            r1_dsx <= ssi_pkg::DIFF_W'(i_word.a_start_x) - ssi_pkg::DIFF_W'(i_word.b_start_x);
            r1_dsy <= ssi_pkg::DIFF_W'(i_word.a_start_y) - ssi_pkg::DIFF_W'(i_word.b_start_y);

            r2_pts <= r1_pts;
            r2_degen <= r1_degen;
            r2_dax <= r1_dax;
            r2_day <= r1_day;
            r2_pbyax <= r1_dby * r1_dax;
            r2_pbxay <= r1_dbx * r1_day;
            r2_pbxsy <= r1_dbx * r1_dsy;
            r2_pbysx <= r1_dby * r1_dsx;
            r2_paxsy <= r1_dax * r1_dsy;
            r2_paysx <= r1_day * r1_dsx;
            r2_mask[0] <= in_span(r1_pts.a_start_x, r1_pts.b_start_x, r1_pts.b_end_x)
                       && in_span(r1_pts.a_start_y, r1_pts.b_start_y, r1_pts.b_end_y);
            r2_mask[1] <= in_span(r1_pts.a_end_x, r1_pts.b_start_x, r1_pts.b_end_x)
                       && in_span(r1_pts.a_end_y, r1_pts.b_start_y, r1_pts.b_end_y);
            r2_mask[2] <= in_span(r1_pts.b_start_x, r1_pts.a_start_x, r1_pts.a_end_x)
                       && in_span(r1_pts.b_start_y, r1_pts.a_start_y, r1_pts.a_end_y);
            r2_mask[3] <= in_span(r1_pts.b_end_x, r1_pts.a_start_x, r1_pts.a_end_x)
                       && in_span(r1_pts.b_end_y, r1_pts.a_start_y, r1_pts.a_end_y);

            r3_pts <= r2_pts;
            r3_degen <= r2_degen;
            r3_mask <= r2_mask;
            r3_dax <= r2_dax;
            r3_day <= r2_day;
            r3_den <= ssi_pkg::WIDE_W'(r2_pbyax) - ssi_pkg::WIDE_W'(r2_pbxay);
            r3_num1 <= ssi_pkg::WIDE_W'(r2_pbxsy) - ssi_pkg::WIDE_W'(r2_pbysx);
            r3_num2 <= ssi_pkg::WIDE_W'(r2_paxsy) - ssi_pkg::WIDE_W'(r2_paysx);

            r4_tag <= n4_tag;
            r4_den <= r3_den;
            r4_plx <= n4_lo * r3_dax;
            r4_ply <= n4_lo * r3_day;
            r4_phx <= n4_hi * r3_dax;
            r4_phy <= n4_hi * r3_day;

            r5_tag <= r4_tag;
            r5_den <= r4_den;
            r5_px <= (ssi_pkg::MUL_W'(r4_phx) <<< ssi_pkg::LO_W) + ssi_pkg::MUL_W'(r4_plx);
            r5_py <= (ssi_pkg::MUL_W'(r4_phy) <<< ssi_pkg::LO_W) + ssi_pkg::MUL_W'(r4_ply);

            r6_div <= n6_div;
        end
    end

    assign o_valid = r_v[5];
    assign o_div = r6_div;

endmodule

// ----- rtl/ssi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection divider
// Restoring division, one quotient bit per stage, for both point coordinates.
// ----------------------------------------------------------------------------
module ssi_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  ssi_pkg::t_div i_div,
    output logic          o_valid,
    output ssi_pkg::t_div o_div
);

    ssi_pkg::t_div w_st [ssi_pkg::QUO_BITS+1];
    logic          w_v  [ssi_pkg::QUO_BITS+1];

    assign w_st[0] = i_div;
    assign w_v[0] = i_valid;

    for (genvar s = 0; s < ssi_pkg::QUO_BITS; s++) begin : g_stage
        localparam int K = ssi_pkg::QUO_BITS - 1 - s;
        ssi_pkg::t_div n_st;
        ssi_pkg::t_div r_st;
        logic r_v;
        logic [ssi_pkg::MUL_W-1:0] tsh;

        always_comb begin
            n_st = w_st[s];
            tsh = ssi_pkg::MUL_W'(w_st[s].dvs) << K;
            if (w_st[s].rem_x >= tsh) begin
                n_st.rem_x = w_st[s].rem_x - tsh;
                n_st.quo_x[K] = 1'b1;
            end
            if (w_st[s].rem_y >= tsh) begin
                n_st.rem_y = w_st[s].rem_y - tsh;
                n_st.quo_y[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st <= n_st;
            end
        end

        assign w_st[s+1] = r_st;
        assign w_v[s+1] = r_v;
    end

    assign o_valid = w_v[ssi_pkg::QUO_BITS];
    assign o_div = w_st[ssi_pkg::QUO_BITS];

endmodule

// ----- rtl/ssi_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection output stage
// Forms the reported points; unless the receiver stalls, one word per cycle
// enters the output register, walking collinear overlap endpoints in order.
// ----------------------------------------------------------------------------
`include "segment_segment_intersection_macros.svh"
module ssi_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  ssi_pkg::t_div      i_head,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output ssi_pkg::t_out_word o_word
);

    logic                       r_valid;
    ssi_pkg::t_out_word         r_word;
    logic [ssi_pkg::NPTS-1:0]   r_done;

    logic [ssi_pkg::NPTS-1:0]   rem_mask;
    logic [ssi_pkg::NPTS-1:0]   first;
    logic [ssi_pkg::NPTS-1:0]   after;
    logic                       out_free;
    logic                       emit;
    logic signed [ssi_pkg::COORD_BITS-1:0] qx, qy;
    ssi_pkg::t_out_word         n_word;
    logic [ssi_pkg::NPTS-1:0]   n_done;

    always_comb begin
        rem_mask = i_head.tag.mask & ~r_done;
        first = rem_mask & (~rem_mask + 1'b1);
        after = rem_mask & ~first;
        out_free = !r_valid || !i_stall;
        emit = i_head_valid && out_free;
        qx = i_head.quo_x[ssi_pkg::COORD_BITS-1:0];
        qy = i_head.quo_y[ssi_pkg::COORD_BITS-1:0];
        n_word.kind = i_head.tag.kind;
        n_word.last = 1'b1;
        n_word.point_x = '0;
        n_word.point_y = '0;
        o_pop = emit;
        n_done = '0;
        case (i_head.tag.kind)
            ssi_pkg::K_CROSS: begin
                n_word.point_x = i_head.tag.pts.a_start_x + (i_head.neg_x ? -qx : qx);
                n_word.point_y = i_head.tag.pts.a_start_y + (i_head.neg_y ? -qy : qy);
            end
            ssi_pkg::K_OVERLAP: begin
                n_word.last = (after == '0);
                o_pop = emit && (after == '0);
                n_done = (after == '0) ? '0 : (r_done | first);
                case (first)
                    4'b0001: begin
                        n_word.point_x = i_head.tag.pts.a_start_x;
                        n_word.point_y = i_head.tag.pts.a_start_y;
                    end
                    4'b0010: begin
                        n_word.point_x = i_head.tag.pts.a_end_x;
                        n_word.point_y = i_head.tag.pts.a_end_y;
                    end
                    4'b0100: begin
                        n_word.point_x = i_head.tag.pts.b_start_x;
                        n_word.point_y = i_head.tag.pts.b_start_y;
                    end
                    default: begin
                        n_word.point_x = i_head.tag.pts.b_end_x;
                        n_word.point_y = i_head.tag.pts.b_end_y;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done <= '0;
        end else begin
            if (out_free) begin
                r_valid <= i_head_valid;
            end
            if (emit) begin
                r_done <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word = r_word;

    `SSI_ASSERT_NOW(a_rem_nonempty, i_clk, i_rst_n,
        i_head_valid && (i_head.tag.kind == ssi_pkg::K_OVERLAP), rem_mask != '0)
    `SSI_ASSERT_NEXT(a_done_cleared, i_clk, i_rst_n, o_pop, r_done == '0)
    `SSI_ASSERT_NOW(a_single_last, i_clk, i_rst_n,
        r_valid && (r_word.kind != ssi_pkg::K_OVERLAP), r_word.last)
    `SSI_ASSERT_NEXT(a_overlap_cont, i_clk, i_rst_n,
        r_valid && !r_word.last, r_valid)

endmodule

// ----- rtl/segment_segment_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment segment intersection
// Usage: one input word carries two segments as signed Q16.16 endpoints.
// Input channel i_valid / o_stall / i_word; output channel o_valid / i_stall /
// o_word. A word moves when valid is high and stall is low.
// Each input word gives one output word, or up to four for a collinear pair
// (one per overlapping endpoint); the last output word of a pair has last set.
// From acceptance to the first output word, a pair passes six front stages,
// one divider stage per quotient bit (34), and the output register.
// One pair is accepted per cycle unless the pipeline is held: a collinear pair
// with more than one overlap endpoint holds the whole pipeline until the output
// stage sends its last word. When the receiver stalls, the output word holds;
// once the last stage is occupied the pipeline freezes and o_stall rises.
// Reset clears all valid bits; no word is in flight afterwards.
// ----------------------------------------------------------------------------
module segment_segment_intersection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ssi_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output ssi_pkg::t_out_word o_word
);

    logic          adv;
    logic          front_v;
    ssi_pkg::t_div front_div;
    logic          head_v;
    ssi_pkg::t_div head_div;
    logic          pop;

    assign adv = !head_v || pop;
    assign o_stall = !adv;

    ssi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_valid (front_v),
        .o_div   (front_div)
    );

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (front_v),
        .i_div   (front_div),
        .o_valid (head_v),
        .o_div   (head_div)
    );

    ssi_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_v),
        .i_head       (head_div),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_word       (o_word)
    );

endmodule

// ----- sim/segment_segment_intersection_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment segment intersection testbench
// Drives segment pairs through the block with random gaps and output stalls.
// An exact wide-integer model predicts every output word. A scoreboard checks
// the output words in order against these predictions.
// ----------------------------------------------------------------------------
module segment_segment_intersection_test;

    localparam int CLK_PERIOD = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM = 370;

    typedef logic signed [127:0] t_big;

    class intersect_scoreboard;
        ssi_pkg::t_out_word pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(string what, ssi_pkg::t_out_word got, ssi_pkg::t_out_word want);
            $display("error: %s got x=%h y=%h kind=%0d last=%0d, %s x=%h y=%h kind=%0d last=%0d",
                     what, got.point_x, got.point_y, got.kind, got.last, "want",
                     want.point_x, want.point_y, want.kind, want.last);
            errors++;
        endtask

        function bit in_span(logic signed [ssi_pkg::COORD_BITS-1:0] v,
                             logic signed [ssi_pkg::COORD_BITS-1:0] e0,
                             logic signed [ssi_pkg::COORD_BITS-1:0] e1);
            if (e0 <= e1) begin
                return (e0 <= v) && (v <= e1);
            end
            return (e1 <= v) && (v <= e0);
        endfunction

        function bit in_unit(t_big n, t_big d);
            t_big an;
            t_big ad;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            if (n == 0) begin
                return 1'b1;
            end
            if ((n < 0) != (d < 0)) begin
                return 1'b0;
            end
            return an <= ad;
        endfunction

        function void push_word(t_big x, t_big y, logic [1:0] kind, logic last);
            ssi_pkg::t_out_word r;
            r.point_x = x[ssi_pkg::COORD_BITS-1:0];
            r.point_y = y[ssi_pkg::COORD_BITS-1:0];
            r.kind = kind;
            r.last = last;
            pending.insert(pending.size(), r);
        endfunction

        // Expected output words for one accepted segment pair.
        function void note_input(ssi_pkg::t_in_word w);
            t_big c[8];
            t_big dax, day, dbx, dby, dsx, dsy, den, cr, num1, num2;
            int n;
            int o;
            c[0] = w.a_start_x; c[1] = w.a_start_y; c[2] = w.a_end_x; c[3] = w.a_end_y;
            c[4] = w.b_start_x; c[5] = w.b_start_y; c[6] = w.b_end_x; c[7] = w.b_end_y;
            if (c[0] == c[2] && c[1] == c[3]) begin
                push_word(0, 0, ssi_pkg::K_DEGEN, 1'b1);
                return;
            end
            dax = c[2] - c[0];
            day = c[3] - c[1];
            dbx = c[6] - c[4];
            dby = c[7] - c[5];
            dsx = c[0] - c[4];
            dsy = c[1] - c[5];
            den = dby * dax - dbx * day;
            if (den == 0) begin
                cr = dax * dsy - day * dsx;
                if (cr != 0) begin
                    push_word(0, 0, ssi_pkg::K_NONE, 1'b1);
                    return;
                end
                n = 0;
                for (int i = 0; i < 4; i++) begin
                    o = (i < 2) ? 4 : 0;
                    if (in_span(c[2*i][31:0], c[o][31:0], c[o+2][31:0]) &&
                        in_span(c[2*i+1][31:0], c[o+1][31:0], c[o+3][31:0])) begin
                        push_word(c[2*i], c[2*i+1], ssi_pkg::K_OVERLAP, 1'b0);
                        n++;
                    end
                end
                if (n == 0) begin
                    push_word(0, 0, ssi_pkg::K_NONE, 1'b1);
                end else begin
                    pending[$].last = 1'b1;
                end
                return;
            end
            num1 = dbx * dsy - dby * dsx;
            num2 = dax * dsy - day * dsx;
            if (in_unit(num1, den) && in_unit(num2, den)) begin
                push_word(c[0] + (num1 * dax) / den, c[1] + (num1 * day) / den,
                          ssi_pkg::K_CROSS, 1'b1);
            end else begin
                push_word(0, 0, ssi_pkg::K_NONE, 1'b1);
            end
        endfunction

        task check_word(ssi_pkg::t_out_word got);
            ssi_pkg::t_out_word want;
            if (pending.size() == 0) begin
                want = '0;
                report("unexpected word", got, want);
                return;
            end
            want = pending.pop_front();
            if (got.point_x !== want.point_x) report("point_x", got, want);
            if (got.point_y !== want.point_y) report("point_y", got, want);
            if (got.kind !== want.kind) report("kind", got, want);
            if (got.last !== want.last) report("last", got, want);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    ssi_pkg::t_in_word i_word;
    logic o_valid;
    logic i_stall;
    ssi_pkg::t_out_word o_word;
    int cycles;
    int stall_left;
    intersect_scoreboard sb;

    segment_segment_intersection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_word(i_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word(o_word);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (cycles > 3000 && cycles < 4500) begin
            i_stall <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_word(ssi_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(w);
    endtask

    function automatic logic signed [31:0] small_coord();
        return 32'(($urandom_range(0, 2000) - 1000) * 65536 + $urandom_range(0, 65535));
    endfunction

    function automatic ssi_pkg::t_in_word make_pair(logic signed [31:0] v[8]);
        ssi_pkg::t_in_word w;
        w.a_start_x = v[0]; w.a_start_y = v[1]; w.a_end_x = v[2]; w.a_end_y = v[3];
        w.b_start_x = v[4]; w.b_start_y = v[5]; w.b_end_x = v[6]; w.b_end_y = v[7];
        return w;
    endfunction

    // Collinear pair: all four endpoints on one line through base along step.
    function automatic ssi_pkg::t_in_word collinear_pair(bit wide_base);
        logic signed [31:0] v[8];
        logic signed [31:0] bx, by, sx, sy;
        int k;
        bx = wide_base ? $urandom : small_coord();
        by = wide_base ? $urandom : small_coord();
        sx = 32'($urandom_range(0, 16) - 8) * 32'($urandom_range(1, 9000));
        sy = 32'($urandom_range(0, 16) - 8) * 32'($urandom_range(1, 9000));
        for (int i = 0; i < 4; i++) begin
            k = $urandom_range(0, 8) - 4;
            v[2*i] = bx + k * sx;
            v[2*i+1] = by + k * sy;
        end
        return make_pair(v);
    endfunction

    function automatic ssi_pkg::t_in_word random_pair();
        logic signed [31:0] v[8];
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return collinear_pair(r < 5);
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = (r < 85) ? small_coord() : $urandom;
        end
        if (r >= 85 && r < 92) begin
            v[6] = v[4] + (v[2] - v[0]);
            v[7] = v[5] + (v[3] - v[1]);
        end else if (r >= 92 && r < 96) begin
            v[2] = v[0];
            v[3] = v[1];
        end
        return make_pair(v);
    endfunction

    initial begin
        logic signed [31:0] d[N_DIRECTED][8];
        logic signed [31:0] v[8];
        int unsigned MX;
        int unsigned MN;
        MX = 32'h7fffffff;
        MN = 32'h80000000;
        sb = new();
        cycles = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_word = '0;
        d = '{
            '{0, 0, 0, 0, 1, 2, 3, 4},
            '{0, 0, 10, 10, 0, 10, 10, 0},
            '{0, 0, 10, 10, 20, 0, 30, 5},
            '{0, 0, 10, 0, 0, 5, 10, 5},
            '{0, 0, 10, 0, 0, 0, 10, 0},
            '{0, 0, 10, 0, 5, 0, 20, 0},
            '{0, 0, 10, 0, 11, 0, 20, 0},
            '{0, 0, 10, 0, 10, 0, 10, 5},
            '{0, 0, 10, 0, 0, 0, 0, 5},
            '{MN, MN, MX, MX, MN, MX, MX, MN},
            '{MX, MN, MN, MX, MX, MX, MN, MN},
            '{MN, MN, MX, MX, MN, MN, MX, MX},
            '{MX, MX, MX, MX, MN, MN, MN, MN},
            '{-3, 7, 3, -7, -1, -1, 1, 1}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            for (int j = 0; j < 8; j++) v[j] = d[i][j];
            send_word(make_pair(v));
        end
        send_word(collinear_pair(1'b0));
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            send_word(random_pair());
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- segment_segment_intersection.f -----
+incdir+rtl
rtl/ssi_pkg.sv
rtl/ssi_front.sv
rtl/ssi_div.sv
rtl/ssi_out.sv
rtl/segment_segment_intersection.sv
sim/segment_segment_intersection_test.sv
